>>> src/clipped_masked_block_blitter_unit_assert.svh
// Assertion macros for the block blitter.
// Each property is clocked by clk and disabled while rst_n is low.
`ifndef CLIPPED_MASKED_BLOCK_BLITTER_UNIT_ASSERT_SVH
`define CLIPPED_MASKED_BLOCK_BLITTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CMBB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cmbb assertion failed");
`define CMBB_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cmbb forbidden condition");
`else
`define CMBB_ASSERT(label, prop)
`define CMBB_ASSERT_NEVER(label, cond)
`endif
`endif

>>> src/cmbb_pkg.sv
`timescale 1ns / 1ps
package cmbb_pkg;

    localparam int MAX_DIM     = 2048;
    localparam int POS_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 12;
    localparam int COORD_W     = 12;
    localparam int PITCH_W     = 13;
    localparam int SCOORD_W    = ((POS_W > COORD_W) ? POS_W : COORD_W) + 2;
    localparam int PIX_W       = 8;
    localparam int MAP_ENTRIES = 256;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);
    localparam int ADDR_BITS   = 24;
    localparam int PROD_W      = COORD_W + PITCH_W;
    localparam int SUM_W       = ((PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS) + 1;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);
    localparam int QCNT_W      = QAW + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_WIDTH   = 3'd0,
        CFG_DEST_HEIGHT  = 3'd1,
        CFG_DEST_PITCH   = 3'd2,
        CFG_ORIGIN_X     = 3'd3,
        CFG_ORIGIN_Y     = 3'd4,
        CFG_BLOCK_WIDTH  = 3'd5,
        CFG_BLOCK_HEIGHT = 3'd6,
        CFG_MASKED_MODE  = 3'd7
    } cfg_index_t;

    typedef enum logic {
        ACT_MAP_LOAD = 1'b0,
        ACT_PIXEL    = 1'b1
    } action_t;

    typedef struct packed {
        logic [DIM_W-1:0]          dest_width;
        logic [DIM_W-1:0]          dest_height;
        logic [PITCH_W-1:0]        dest_pitch;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [DIM_W-1:0]          block_width;
        logic [DIM_W-1:0]          block_height;
        logic                      masked_mode;
    } cfg_t;

    typedef struct packed {
        logic               is_load;
        logic [MAP_AW-1:0]  map_index;
        logic [PIX_W-1:0]   map_value;
        logic [PIX_W-1:0]   pixel;
        logic               we;
        logic               use_map;
        logic               done;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } q_entry_t;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done_push;
    } front_stat_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_stat_t;

    function automatic logic [DIM_W:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W:0] r;
        if (v == '0) begin
            r = (DIM_W + 1)'(1);
        end else if ((DIM_W + 1)'(v) > (DIM_W + 1)'(MAX_DIM)) begin
            r = (DIM_W + 1)'(MAX_DIM);
        end else begin
            r = (DIM_W + 1)'(v);
        end
        return r;
    endfunction

endpackage

>>> src/cmbb_ram.sv
`timescale 1ns / 1ps
module cmbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/cmbb_front.sv
`timescale 1ns / 1ps
module cmbb_front
    import cmbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               accept,
    input  logic               action,
    input  logic [MAP_AW-1:0]  map_index,
    input  logic [PIX_W-1:0]   map_value,
    input  logic [PIX_W-1:0]   pixel,
    input  logic               first_pixel,
    output q_entry_t           entry,
    output front_stat_t        stat
);

    logic [POS_W-1:0]           col_reg, col_next;
    logic [POS_W-1:0]           row_reg, row_next;
    logic [POS_W-1:0]           col0, row0;
    logic [DIM_W:0]             bw, bh;
    logic signed [SCOORD_W-1:0] x_s, y_s;
    logic                       in_dest, opaque;
    logic                       col_wrap, row_wrap;

    always_comb
    begin
        bw   = clamp_dim(cfg.block_width);
        bh   = clamp_dim(cfg.block_height);
        col0 = first_pixel ? '0 : col_reg;
        row0 = first_pixel ? '0 : row_reg;

        x_s = SCOORD_W'(cfg.origin_x) + SCOORD_W'(col0);
        y_s = SCOORD_W'(cfg.origin_y) + SCOORD_W'(row0);
        in_dest = !x_s[SCOORD_W-1] && !y_s[SCOORD_W-1]
                  && (x_s[SCOORD_W-2:0] < (SCOORD_W - 1)'(cfg.dest_width))
                  && (y_s[SCOORD_W-2:0] < (SCOORD_W - 1)'(cfg.dest_height));
        opaque = !cfg.masked_mode || (pixel != '0);

        col_wrap = ((DIM_W + 1)'(col0) + (DIM_W + 1)'(1)) >= bw;
        row_wrap = ((DIM_W + 1)'(row0) + (DIM_W + 1)'(1)) >= bh;

        col_next = col_reg;
        row_next = row_reg;
        if (accept && (action == ACT_PIXEL))
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row0 + POS_W'(1);
            end
            else
            begin
                col_next = col0 + POS_W'(1);
                row_next = row0;
            end
        end

        entry.is_load   = (action == ACT_MAP_LOAD);
        entry.map_index = map_index;
        entry.map_value = map_value;
        entry.pixel     = pixel;
        entry.we        = (action == ACT_PIXEL) && in_dest && opaque;
        entry.use_map   = cfg.masked_mode;
        entry.done      = (action == ACT_PIXEL) && col_wrap && row_wrap;
        entry.x         = x_s[COORD_W-1:0];
        entry.y         = y_s[COORD_W-1:0];

        stat.col       = col_reg;
        stat.row       = row_reg;
        stat.done_push = accept && entry.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> src/cmbb_queue.sv
`timescale 1ns / 1ps
module cmbb_queue
    import cmbb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output q_stat_t  stat
);

    q_entry_t          slot_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
        head       = slot_reg[rd_ptr_reg];
        stat.count = count_reg;
        stat.full  = (count_reg == QCNT_W'(QDEPTH));
        stat.empty = (count_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/cmbb_back.sv
`timescale 1ns / 1ps
module cmbb_back
    import cmbb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PITCH_W-1:0]   pitch,
    input  q_entry_t             head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 write_enable,
    output logic [ADDR_BITS-1:0] write_address,
    output logic [PIX_W-1:0]     write_data,
    output logic                 block_done
);

    logic                 advance;
    logic                 ram_we, ram_re;
    logic [PIX_W-1:0]     map_data;
    logic [SUM_W-1:0]     addr_sum;

    logic                 b1_valid_reg, b1_valid_next;
    logic                 b1_we_reg;
    logic                 b1_use_map_reg;
    logic                 b1_done_reg;
    logic [PIX_W-1:0]     b1_pixel_reg;
    logic [PROD_W-1:0]    b1_prod_reg;
    logic [COORD_W-1:0]   b1_y_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_we_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic [PIX_W-1:0]     out_data_reg;
    logic                 out_done_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !empty;
    assign ram_we  = pop && head.is_load;
    assign ram_re  = pop && !head.is_load && head.we && head.use_map;

    cmbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAP_ENTRIES)
    ) u_color_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.map_index),
        .wdata (head.map_value),
        .re    (ram_re),
        .raddr (head.pixel),
        .rdata (map_data)
    );

    always_comb
    begin
        b1_valid_next  = advance ? pop : b1_valid_reg;
        out_valid_next = advance ? b1_valid_reg : out_valid_reg;
        addr_sum       = SUM_W'(b1_prod_reg) + SUM_W'(b1_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_we_reg      <= head.we;
            b1_use_map_reg <= head.use_map;
            b1_done_reg    <= head.done;
            b1_pixel_reg   <= head.pixel;
            b1_prod_reg    <= PROD_W'(head.x) * PROD_W'(pitch);
            b1_y_reg       <= head.y;
        end
        if (advance && b1_valid_reg)
        begin
            out_we_reg   <= b1_we_reg;
            out_done_reg <= b1_done_reg;
            out_addr_reg <= b1_we_reg ? addr_sum[ADDR_BITS-1:0] : '0;
            if (!b1_we_reg)
            begin
                out_data_reg <= '0;
            end
            else
            begin
                out_data_reg <= b1_use_map_reg ? map_data : b1_pixel_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = out_we_reg;
    assign write_address = out_addr_reg;
    assign write_data    = out_data_reg;
    assign block_done    = out_done_reg;

endmodule

>>> src/clipped_masked_block_blitter_unit.sv
`timescale 1ns / 1ps
// Channel   | Handshake           | Payload
// ----------+---------------------+---------------------------------------------
// input     | in_valid / in_stall | action map_index map_value pixel first_pixel
// output    | out_valid/out_stall | write_enable write_address write_data
//           |                     | block_done
// config    | cfg_we              | cfg_index cfg_data
//
// One transaction per clock in steady state while out_stall is low; items pass
// front classify, multiply and color map read, and the output register.
// A four-entry queue decouples front and back; in_stall rises only when it is
// full. The color map RAM reads and writes in queue order in the back part.
// Reset clears the position counters, queue and valid flags; configuration
// registers take their documented reset values. No clearing pass is needed.
`include "clipped_masked_block_blitter_unit_assert.svh"
module clipped_masked_block_blitter_unit
    import cmbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [MAP_AW-1:0]     map_index,
    input  logic [PIX_W-1:0]      map_value,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  first_pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  write_enable,
    output logic [ADDR_BITS-1:0]  write_address,
    output logic [PIX_W-1:0]      write_data,
    output logic                  block_done
);

    cfg_t        cfg_reg, cfg_next;
    logic        accept;
    logic        pop;
    q_entry_t    front_entry;
    q_entry_t    head;
    front_stat_t front_stat;
    q_stat_t     q_stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEST_WIDTH:   cfg_next.dest_width   = cfg_data[DIM_W-1:0];
                CFG_DEST_HEIGHT:  cfg_next.dest_height  = cfg_data[DIM_W-1:0];
                CFG_DEST_PITCH:   cfg_next.dest_pitch   = cfg_data[PITCH_W-1:0];
                CFG_ORIGIN_X:     cfg_next.origin_x     = $signed(cfg_data[COORD_W-1:0]);
                CFG_ORIGIN_Y:     cfg_next.origin_y     = $signed(cfg_data[COORD_W-1:0]);
                CFG_BLOCK_WIDTH:  cfg_next.block_width  = cfg_data[DIM_W-1:0];
                CFG_BLOCK_HEIGHT: cfg_next.block_height = cfg_data[DIM_W-1:0];
                CFG_MASKED_MODE:  cfg_next.masked_mode  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width   <= DIM_W'(320);
            cfg_reg.dest_height  <= DIM_W'(200);
            cfg_reg.dest_pitch   <= PITCH_W'(200);
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.block_width  <= DIM_W'(1);
            cfg_reg.block_height <= DIM_W'(1);
            cfg_reg.masked_mode  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    cmbb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .action      (action),
        .map_index   (map_index),
        .map_value   (map_value),
        .pixel       (pixel),
        .first_pixel (first_pixel),
        .entry       (front_entry),
        .stat        (front_stat)
    );

    cmbb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    cmbb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pitch         (cfg_reg.dest_pitch),
        .head          (head),
        .empty         (q_stat.empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_enable  (write_enable),
        .write_address (write_address),
        .write_data    (write_data),
        .block_done    (block_done)
    );

    `CMBB_ASSERT(a_no_write_zero, out_valid && !write_enable |-> write_address == '0 && write_data == '0)
    `CMBB_ASSERT(a_done_wraps, front_stat.done_push |=> front_stat.col == '0 && front_stat.row == '0)
    `CMBB_ASSERT(a_queue_bound, q_stat.count <= QCNT_W'(QDEPTH))
    `CMBB_ASSERT_NEVER(a_queue_flags, q_stat.full && q_stat.empty)

endmodule
